/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expression that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

/* hw/rtl/tfr_pkg.sv */
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared constants, codes and types of the two-fragment packet reassembler.
// ----------------------------------------------------------------------------
package tfr_pkg;

  localparam int BUFFER_BYTES_DEF = 512;
  localparam int SEQ_SHIFT        = 4;

  localparam int STATUS_W  = 3;
  localparam int LEN_W     = 10;
  localparam int SEQ_W     = 4;
  localparam int BYTE_W    = 8;
  localparam int RIDX_W    = 9;
  localparam int MASK_W    = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 10;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_TAKEN    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HELD     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SMALL    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_READ     = 3'd6;

  // opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 1'd1;

  localparam logic [LEN_W-1:0]  CAPACITY_RST = 10'd512;
  localparam logic [MASK_W-1:0] MASK_RST     = 4'd1;

  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] air_byte;
    logic              end_of_packet;
    logic [RIDX_W-1:0] read_index;
  } tfr_req_t;

  // result fields leaving the update logic; rd_hit selects store data
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    payload_length;
    logic [SEQ_W-1:0]    packet_sequence;
    logic                rd_hit;
  } tfr_stage_t;

endpackage

/* hw/rtl/tfr_if.sv */
// ----------------------------------------------------------------------------
// tfr_if
// Valid/ready channels: request beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface tfr_req_if;
  import tfr_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] air_byte;
  logic              end_of_packet;
  logic [RIDX_W-1:0] read_index;
  modport source (output valid, opcode, air_byte, end_of_packet, read_index,
                  input ready);
  modport sink   (input valid, opcode, air_byte, end_of_packet, read_index,
                  output ready);
endinterface

interface tfr_rsp_if;
  import tfr_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    payload_length;
  logic [SEQ_W-1:0]    packet_sequence;
  logic [BYTE_W-1:0]   read_data;
  modport source (output valid, status, payload_length, packet_sequence, read_data,
                  input ready);
  modport sink   (input valid, status, payload_length, packet_sequence, read_data,
                  output ready);
endinterface

interface tfr_cfg_if;
  import tfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/tfr_ram.sv */
// ----------------------------------------------------------------------------
// tfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/tfr_ctrl.sv */
// ----------------------------------------------------------------------------
// tfr_ctrl
// Packet tracking, fragment bookkeeping and store addressing for each beat.
// ----------------------------------------------------------------------------
module tfr_ctrl #(
  parameter int BUFFER_BYTES = tfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  tfr_pkg::tfr_req_t               req,
  input  logic                            cfg_we,
  input  logic [tfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tfr_pkg::CFG_DAT_W-1:0]   cfg_data,
  output tfr_pkg::tfr_stage_t             stage,
  output logic                            ram_we,
  output logic [$clog2(BUFFER_BYTES)-1:0] ram_waddr,
  output logic [tfr_pkg::BYTE_W-1:0]      ram_wdata,
  output logic                            ram_re,
  output logic [$clog2(BUFFER_BYTES)-1:0] ram_raddr
);
  import tfr_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int LW = $clog2(BUFFER_BYTES + 1);
  localparam int PW = $clog2(BUFFER_BYTES + 2);
  localparam int WW = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;

  logic [LW-1:0]     held_length, held_length_next;
  logic [SEQ_W-1:0]  held_sequence, held_sequence_next;
  logic              held_valid, held_valid_next;
  logic [BYTE_W-1:0] current_header, current_header_next;
  logic [PW-1:0]     packet_position, packet_position_next;
  logic [LW-1:0]     write_offset, write_offset_next;
  logic              overflowed, overflowed_next;
  logic [LW-1:0]     completed_length, completed_length_next;
  logic [LEN_W-1:0]  output_capacity;
  logic [MASK_W-1:0] split_mask;

  logic              split_new, appends_new, split_cur, appends_cur;
  logic [SEQ_W-1:0]  seq_new, seq_cur;
  logic [WW-1:0]     addr_w, total_w, ridx_w;
  logic [PW-1:0]     pos_inc;
  logic              addr_ok, ov_now;

  assign seq_new     = req.air_byte[SEQ_SHIFT +: SEQ_W];
  assign seq_cur     = current_header[SEQ_SHIFT +: SEQ_W];
  assign split_new   = |(req.air_byte[MASK_W-1:0] & split_mask);
  assign split_cur   = |(current_header[MASK_W-1:0] & split_mask);
  assign appends_new = split_new && held_valid && (held_sequence == seq_new);
  assign appends_cur = split_cur && held_valid && (held_sequence == seq_cur);

  assign addr_w  = WW'(write_offset) + WW'(packet_position) - WW'(1);
  assign addr_ok = addr_w < WW'(BUFFER_BYTES);
  assign ov_now  = overflowed || !addr_ok;
  // position saturates one past the store so addresses stay out of range
  assign pos_inc = (WW'(packet_position) <= WW'(BUFFER_BYTES)) ?
                   packet_position + PW'(1) : packet_position;
  assign total_w = WW'(write_offset) + WW'(pos_inc) - WW'(1);
  assign ridx_w  = WW'(req.read_index);

  always_comb begin
    held_length_next      = held_length;
    held_sequence_next    = held_sequence;
    held_valid_next       = held_valid;
    current_header_next   = current_header;
    packet_position_next  = packet_position;
    write_offset_next     = write_offset;
    overflowed_next       = overflowed;
    completed_length_next = completed_length;
    stage                 = '0;
    stage.status          = ST_TAKEN;

    if (req.opcode == OP_READ) begin
      stage.status         = ST_READ;
      stage.payload_length = LEN_W'(completed_length);
      stage.rd_hit         = (ridx_w < WW'(completed_length)) &&
                             (ridx_w < WW'(BUFFER_BYTES));
    end else if (packet_position == '0) begin
      // header beat
      current_header_next   = req.air_byte;
      completed_length_next = '0;
      overflowed_next       = 1'b0;
      write_offset_next     = appends_new ? held_length : '0;
      packet_position_next  = PW'(1);
      if (req.end_of_packet) begin
        stage.status          = ST_BAD;
        stage.packet_sequence = seq_new;
        held_valid_next       = 1'b0;
        held_length_next      = '0;
        held_sequence_next    = '0;
        packet_position_next  = '0;
      end
    end else begin
      overflowed_next      = ov_now;
      packet_position_next = pos_inc;
      if (req.end_of_packet) begin
        stage.packet_sequence = seq_cur;
        packet_position_next  = '0;
        priority if (ov_now) begin
          stage.status       = ST_OVERFLOW;
          held_valid_next    = 1'b0;
          held_length_next   = '0;
          held_sequence_next = '0;
        end else if (!split_cur || appends_cur) begin
          held_valid_next      = 1'b0;
          held_length_next     = '0;
          held_sequence_next   = '0;
          stage.payload_length = LEN_W'(total_w);
          if (total_w > WW'(output_capacity)) begin
            stage.status = ST_SMALL;
          end else begin
            stage.status          = ST_COMPLETE;
            completed_length_next = LW'(total_w);
          end
        end else begin
          held_length_next     = LW'(total_w);
          held_sequence_next   = seq_cur;
          held_valid_next      = 1'b1;
          stage.status         = ST_HELD;
          stage.payload_length = LEN_W'(total_w);
        end
      end
    end
  end

  assign ram_we    = fire && (req.opcode == OP_PUSH) && (packet_position != '0) && addr_ok;
  assign ram_waddr = AW'(addr_w);
  assign ram_wdata = req.air_byte;
  assign ram_re    = fire && (req.opcode == OP_READ);
  assign ram_raddr = AW'(req.read_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_length      <= '0;
      held_sequence    <= '0;
      held_valid       <= 1'b0;
      current_header   <= '0;
      packet_position  <= '0;
      write_offset     <= '0;
      overflowed       <= 1'b0;
      completed_length <= '0;
    end else if (fire) begin
      held_length      <= held_length_next;
      held_sequence    <= held_sequence_next;
      held_valid       <= held_valid_next;
      current_header   <= current_header_next;
      packet_position  <= packet_position_next;
      write_offset     <= write_offset_next;
      overflowed       <= overflowed_next;
      completed_length <= completed_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity <= CAPACITY_RST;
      split_mask      <= MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: output_capacity <= cfg_data[LEN_W-1:0];
        CFG_MASK:     split_mask      <= cfg_data[MASK_W-1:0];
        default:      ;
      endcase
    end
  end

endmodule

/* hw/rtl/tfr_out.sv */
// ----------------------------------------------------------------------------
// tfr_out
// Store-read stage and result register; sets the request-side ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfr_out (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  tfr_pkg::tfr_stage_t        stage,
  input  logic [tfr_pkg::BYTE_W-1:0] ram_rdata,
  output logic                       in_ready,
  tfr_rsp_if.source                  rsp
);
  import tfr_pkg::*;

  tfr_stage_t        s1;
  logic              s1_valid;
  logic              s1_move;
  logic              out_valid;
  tfr_stage_t        out_fields;
  logic [BYTE_W-1:0] out_rdata;

  // store data for s1 stays on the RAM output until s1 moves on
  assign s1_move  = !out_valid || rsp.ready;
  assign in_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1 <= stage;
    end
    if (s1_move) begin
      out_fields <= s1;
      out_rdata  <= s1.rd_hit ? ram_rdata : '0;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_fields.status;
  assign rsp.payload_length  = out_fields.payload_length;
  assign rsp.packet_sequence = out_fields.packet_sequence;
  assign rsp.read_data       = out_rdata;

  `ASSERT_CLK(a_s1_hold, clk, rst, s1_valid && !s1_move |=> s1_valid && $stable(s1),
              "stalled read stage changed")
  `ASSERT_CLK(a_rdata_zero, clk, rst,
              out_valid && (out_fields.status != ST_READ) |-> out_rdata == '0,
              "read data on a non-read result")
  `ASSERT_CLK(a_taken_quiet, clk, rst,
              out_valid && (out_fields.status == ST_TAKEN) |->
              (out_fields.payload_length == '0) && (out_fields.packet_sequence == '0),
              "byte-taken result carries length or sequence")

endmodule

/* hw/rtl/two_fragment_packet_reassembler.sv */
// ----------------------------------------------------------------------------
// two_fragment_packet_reassembler
// Joins received packets of up to two fragments and serves payload reads.
// ----------------------------------------------------------------------------
// Usage:
//   req : one beat per received byte (opcode push) or per payload read
//         (opcode read, read_index). The first pushed byte of a packet is
//         its header; end_of_packet marks the last byte.
//   rsp : exactly one result beat per request beat, in order.
//   cfg : register writes (index 0 output_capacity, 1 split_mask), always
//         ready; write only while no request is in flight.
// From request beat to result beat, a request passes the read stage,
// where the payload store read is registered, then the result register.
// Throughput is one beat per cycle while rsp is ready: a byte push is one
// store write, a read is one store read, never both at once.
// When rsp stalls, one more request is taken into the read stage, then
// req.ready drops until the result register empties.
// Reset (rst, synchronous) clears the packet tracker and pending fragment
// and restores the register defaults; the store is left as is, since no
// read reaches past the completed length.
// ----------------------------------------------------------------------------
module two_fragment_packet_reassembler #(
  parameter int BUFFER_BYTES = tfr_pkg::BUFFER_BYTES_DEF
) (
  input logic       clk,
  input logic       rst,
  tfr_req_if.sink   req,
  tfr_rsp_if.source rsp,
  tfr_cfg_if.sink   cfg
);
  import tfr_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);

  tfr_req_t          req_s;
  tfr_stage_t        stage;
  logic              fire;
  logic              in_ready;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  assign req.ready = in_ready;
  assign fire      = req.valid && in_ready;
  assign cfg.ready = 1'b1;

  assign req_s.opcode        = req.opcode;
  assign req_s.air_byte      = req.air_byte;
  assign req_s.end_of_packet = req.end_of_packet;
  assign req_s.read_index    = req.read_index;

  // header, position and fragment tracking; computes the result fields
  tfr_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .req       (req_s),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .stage     (stage),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  // shared payload store: fragments land at their final offsets
  tfr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tfr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .stage     (stage),
    .ram_rdata (ram_rdata),
    .in_ready  (in_ready),
    .rsp       (rsp)
  );

endmodule
